// ===== rtl/gcbk_pkg.sv =====
// gcbk_pkg: shared types and constants for the grid cell best keypoint selector
// holds status and register codes, stream packing widths and the cell entry layout
// no dependencies
package gcbk_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd2;
  localparam int unsigned CFG_DATA_W = 12;

  // result status codes
  localparam int unsigned STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_STORED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WEAKER        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DRAIN_OCCUPIED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DRAIN_EMPTY   = 3'd4;

  // input item kinds
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // stream widths, data packed from bit 0 and padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 96;

  // divider works on whole pixels: 16-bit 12.4 position gives 12 quotient bits
  localparam int unsigned DIV_BITS = 12;
  localparam int unsigned IDX_W    = 24;

  typedef struct packed {
    logic [31:0] strength;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] handle;
  } cell_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [9:0]          cell_no;
    logic [15:0]         x;
    logic [15:0]         y;
    logic [31:0]         strength;
    logic [15:0]         tag;
  } result_t;

endpackage

// ===== rtl/grid_cell_best_keypoint_select.sv =====
// Grid cell best keypoint selector top level: cell store, shared divider and sequencer
// Depends on gcbk_pkg for codes, stream widths and the cell entry layout
//
// One item at a time. For an offer, a single restoring divider produces the column and
// then the row quotient, one bit per cycle, followed by the row-times-cells-across
// multiply-add, the store range check, a registered memory read, the compare-and-write
// and the output load. An offer whose column lies beyond the grid goes from the
// multiply-add straight to the output load, one whose cell lies beyond the store from
// the range check. A drain takes the read, the return-and-clear and the output load, or
// only the output load when the named cell is beyond the store. The output load waits
// while the previous result is still held. After reset the store is swept to zero one
// entry a cycle while in_tready stays low; configuration writes are taken at any time. The
// result register lets the next item be accepted while a result still waits to be taken.
module grid_cell_best_keypoint_select #(
  parameter int unsigned NUM_CELLS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] x_position, [31:16] y_position, [63:32] strength, [79:64] point_tag,
  // [89:80] cell_to_drain, [95:90] zero
  input  logic [gcbk_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] kind
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [9:0] cell_number, [25:10] out_x, [41:26] out_y, [73:42] out_strength,
  // [89:74] out_tag, [95:90] zero
  output logic [gcbk_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [gcbk_pkg::STATUS_W-1:0]        out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gcbk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gcbk_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gcbk_pkg::*;

  localparam int unsigned AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_IDX   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state_r, state_nxt;

  logic [11:0] cell_height_r;
  logic [11:0] cell_width_r;
  logic [10:0] cells_across_r;

  // latched item
  logic        kind_r;
  logic [15:0] x_r, y_r;
  logic [31:0] s_r;
  logic [15:0] tag_r;
  logic [9:0]  dcell_r;

  // shared divider
  logic [11:0] rem_r, dvd_r, dsr_r;
  logic [3:0]  div_cnt_r;
  logic        div_pass_r;
  logic [13:0] trial;
  logic        q_bit;
  logic [11:0] rem_step;
  logic [11:0] q_step;
  logic [11:0] ch_eff, cw_eff;

  logic [11:0] col_r, row_r;
  logic [22:0] prod;
  logic [IDX_W-1:0] idx_r;

  logic [AW-1:0] addr_r;
  cell_entry_t   mem [NUM_CELLS];
  cell_entry_t   mem_q_r;
  cell_entry_t   mem_wdata;
  logic          mem_we;

  result_t res_r;

  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]    out_tuser_r;

  logic in_acc;
  logic out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign ch_eff = (cell_height_r == 12'd0) ? 12'd1 : cell_height_r;
  assign cw_eff = (cell_width_r == 12'd0) ? 12'd1 : cell_width_r;

  // one restoring step: shift in the next dividend bit and try the subtract
  assign trial    = {1'b0, rem_r, dvd_r[11]} - {2'b00, dsr_r};
  assign q_bit    = !trial[13];
  assign rem_step = q_bit ? trial[11:0] : {rem_r[10:0], dvd_r[11]};
  assign q_step   = {dvd_r[10:0], q_bit};

  assign prod = row_r * cells_across_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_height_r  <= 12'd32;
      cell_width_r   <= 12'd32;
      cells_across_r <= 11'd21;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_HEIGHT:  cell_height_r  <= cfg_data;
        REG_CELL_WIDTH:   cell_width_r   <= cfg_data;
        REG_CELLS_ACROSS: cells_across_r <= {1'b0, cfg_data[9:0]} | {cfg_data[10], 10'd0};
        default: ;
      endcase
    end
  end

  // cell store
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_CMP) begin
      if (kind_r == KIND_DRAIN) begin
        mem_we = 1'b1;
      end else if (s_r > mem_q_r.strength) begin
        mem_we    = 1'b1;
        mem_wdata = '{strength: s_r, y: y_r, x: x_r, handle: tag_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    mem_q_r <= mem[addr_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (addr_r == AW'(NUM_CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == KIND_DRAIN) begin
            state_nxt = (32'(in_tdata[89:80]) >= NUM_CELLS) ? S_OUT : S_RD;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV:   if (div_pass_r && div_cnt_r == 4'(DIV_BITS - 1)) state_nxt = S_MUL;
      S_MUL:   state_nxt = (col_r >= {1'b0, cells_across_r}) ? S_OUT : S_IDX;
      S_IDX:   state_nxt = (32'(idx_r) >= NUM_CELLS) ? S_OUT : S_RD;
      S_RD:    state_nxt = S_CMP;
      S_CMP:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      div_cnt_r   <= '0;
      div_pass_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        addr_r <= addr_r + AW'(1);
      end
      if (in_acc) begin
        addr_r     <= AW'(in_tdata[89:80]);
        div_cnt_r  <= '0;
        div_pass_r <= 1'b0;
      end
      if (state_r == S_DIV) begin
        if (div_cnt_r == 4'(DIV_BITS - 1)) begin
          div_cnt_r  <= '0;
          div_pass_r <= 1'b1;
        end else begin
          div_cnt_r <= div_cnt_r + 4'd1;
        end
      end
      if (state_r == S_IDX) begin
        addr_r <= AW'(idx_r);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_tuser;
      x_r     <= in_tdata[15:0];
      y_r     <= in_tdata[31:16];
      s_r     <= in_tdata[63:32];
      tag_r   <= in_tdata[79:64];
      dcell_r <= in_tdata[89:80];
      // column first: whole-pixel x over cell width
      rem_r   <= '0;
      dvd_r   <= in_tdata[15:4];
      dsr_r   <= cw_eff;
      res_r   <= '{status: ST_DRAIN_EMPTY, cell_no: in_tdata[89:80], default: '0};
    end
    if (state_r == S_DIV) begin
      if (div_cnt_r == 4'(DIV_BITS - 1) && !div_pass_r) begin
        col_r <= q_step;
        rem_r <= '0;
        dvd_r <= y_r[15:4];
        dsr_r <= ch_eff;
      end else begin
        rem_r <= rem_step;
        dvd_r <= q_step;
        if (div_cnt_r == 4'(DIV_BITS - 1)) begin
          row_r <= q_step;
        end
      end
    end
    if (state_r == S_MUL) begin
      idx_r <= {1'b0, prod} + {12'd0, col_r};
      res_r <= '{status: ST_OUTSIDE, default: '0};
    end
    if (state_r == S_IDX) begin
      res_r <= '{status: ST_OUTSIDE, cell_no: idx_r[9:0], default: '0};
    end
    if (state_r == S_CMP) begin
      if (kind_r == KIND_DRAIN) begin
        res_r <= '{status: (mem_q_r.strength != 32'd0) ? ST_DRAIN_OCCUPIED : ST_DRAIN_EMPTY,
                   cell_no: dcell_r, x: mem_q_r.x, y: mem_q_r.y,
                   strength: mem_q_r.strength, tag: mem_q_r.handle};
      end else begin
        res_r <= '{status: (s_r > mem_q_r.strength) ? ST_STORED : ST_WEAKER,
                   cell_no: idx_r[9:0], default: '0};
      end
    end
    if (state_r == S_OUT && out_free) begin
      out_tuser_r <= res_r.status;
      out_tdata_r <= {6'd0, res_r.tag, res_r.strength, res_r.y, res_r.x, res_r.cell_no};
    end
  end

  // offers and out-of-grid results never carry keypoint data
  a_offer_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_STORED || out_tuser == ST_WEAKER ||
                    out_tuser == ST_OUTSIDE)) |-> (out_tdata[89:10] == '0))
    else $error("offer result carries keypoint data");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result register loaded outside the output state");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_RD))
    else $error("compare without a preceding store read");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < 4'(DIV_BITS)))
    else $error("divider step count out of range");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !(out_valid_r && $rose(out_valid_r)))
    else $error("result produced during store clearing");

endmodule

// ===== tb/tb_grid_cell_best_keypoint_select.sv =====
// testbench for grid_cell_best_keypoint_select: a directed pass, register extremes and
// random keypoint offers and cell drains, checked against a cycle-free model of the cell store
// depends on gcbk_pkg and the rtl top level only
`timescale 1ns / 100ps

module tb_grid_cell_best_keypoint_select;
  import gcbk_pkg::*;

  localparam int unsigned NUM_CELLS   = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_PCT    = 27;
  // index past the last register, written to show it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = KIND_OFFER;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_CELL_HEIGHT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // model of the cell store and registers
  logic [31:0] best_strength [NUM_CELLS];
  logic [15:0] best_x [NUM_CELLS];
  logic [15:0] best_y [NUM_CELLS];
  logic [15:0] best_tag [NUM_CELLS];
  logic [11:0] cur_cell_h;
  logic [11:0] cur_cell_w;
  logic [10:0] cur_cells_across;

  result_t     predicted_results [$];
  int unsigned filled_cells [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;

  grid_cell_best_keypoint_select uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_cell_best_keypoint_select] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= !out_stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // works out the result of one item and updates the cell store
  function automatic result_t predict_cell_update(logic kind, logic [15:0] px,
                                                  logic [15:0] py, logic [31:0] ps,
                                                  logic [15:0] ptag, logic [9:0] dcell);
    result_t     r;
    int unsigned ch16;
    int unsigned cw16;
    int unsigned row;
    int unsigned col;
    int unsigned idx;
    r = '0;
    if (kind == KIND_DRAIN) begin
      r.cell_no  = dcell;
      r.status   = (best_strength[dcell] != 0) ? ST_DRAIN_OCCUPIED : ST_DRAIN_EMPTY;
      r.x        = best_x[dcell];
      r.y        = best_y[dcell];
      r.strength = best_strength[dcell];
      r.tag      = best_tag[dcell];
      best_strength[dcell] = '0;
      best_x[dcell]        = '0;
      best_y[dcell]        = '0;
      best_tag[dcell]      = '0;
      return r;
    end
    // a zero cell size behaves as one pixel
    ch16 = ((cur_cell_h == 0) ? 1 : cur_cell_h) * 16;
    cw16 = ((cur_cell_w == 0) ? 1 : cur_cell_w) * 16;
    row  = py / ch16;
    col  = px / cw16;
    if (col >= cur_cells_across) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    idx       = row * cur_cells_across + col;
    r.cell_no = idx[9:0];
    if (idx >= NUM_CELLS) begin
      r.status = ST_OUTSIDE;
    end else if (ps > best_strength[idx]) begin
      r.status           = ST_STORED;
      best_strength[idx] = ps;
      best_x[idx]        = px;
      best_y[idx]        = py;
      best_tag[idx]      = ptag;
      filled_cells = {filled_cells, idx};
      if (filled_cells.size() > 64) void'(filled_cells.pop_front());
    end else begin
      r.status = ST_WEAKER;
    end
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    logic [9:0]  got_cell;
    logic [15:0] got_x;
    logic [15:0] got_y;
    logic [31:0] got_s;
    logic [15:0] got_tag;
    if (rst_n && out_tvalid && out_tready) begin
      got_cell = out_tdata[9:0];
      got_x    = out_tdata[25:10];
      got_y    = out_tdata[41:26];
      got_s    = out_tdata[73:42];
      got_tag  = out_tdata[89:74];
      if (predicted_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected item: st=%0d cell=%0d", out_tuser, got_cell);
      end else begin
        want = predicted_results.pop_front();
        if (out_tuser != want.status || got_cell != want.cell_no || got_x != want.x ||
            got_y != want.y || got_s != want.strength || got_tag != want.tag) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display({"mismatch: want st=%0d cell=%0d x=%h y=%h s=%h tag=%h, ",
                      "got st=%0d cell=%0d x=%h y=%h s=%h tag=%h"},
                     want.status, want.cell_no, want.x, want.y, want.strength, want.tag,
                     out_tuser, got_cell, got_x, got_y, got_s, got_tag);
        end
      end
    end
  end

  task automatic send_item(logic kind, logic [15:0] px, logic [15:0] py, logic [31:0] ps,
                           logic [15:0] ptag, logic [9:0] dcell);
    result_t pred;
    @(negedge clk);
    while (in_gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, dcell, ptag, ps, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_cell_update(kind, px, py, ps, ptag, dcell);
    predicted_results = {predicted_results, pred};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_CELL_HEIGHT:  cur_cell_h = value;
      REG_CELL_WIDTH:   cur_cell_w = value;
      REG_CELLS_ACROSS: cur_cells_across = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_item(KIND_DRAIN, 16'h0, 16'h0, 32'h0, 16'h0, 10'd0);
    // zero strength never beats an empty cell
    send_item(KIND_OFFER, 16'h0, 16'h0, 32'h0, 16'h0001, 10'd0);
    send_item(KIND_OFFER, 16'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
    // equal strength is kept out
    send_item(KIND_OFFER, 16'd15, 16'd15, 32'hFFFF_FFFF, 16'h1234, 10'd0);
    send_item(KIND_DRAIN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 10'd0);
    send_item(KIND_DRAIN, 16'h0, 16'h0, 32'h0, 16'h0, 10'd0);
    // column past the grid, then a cell past the store
    send_item(KIND_OFFER, 16'hFFFF, 16'h0, 32'd3, 16'h0002, 10'd0);
    send_item(KIND_OFFER, 16'd10240, 16'hFFFF, 32'd3, 16'h0003, 10'd0);
    send_item(KIND_OFFER, 16'd10751, 16'd24575, 32'd5, 16'h5A5A, 10'd0);
    send_item(KIND_OFFER, 16'd10240, 16'd24064, 32'd6, 16'hA5A5, 10'd0);
    send_item(KIND_DRAIN, 16'h0, 16'h0, 32'h0, 16'h0, 10'd1007);
    send_item(KIND_OFFER, 16'd0, 16'd24576, 32'h8000_0000, 16'h0004, 10'd0);
    send_item(KIND_DRAIN, 16'h0, 16'h0, 32'h0, 16'h0, 10'd1023);
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_CELL_HEIGHT, 12'd0);
    write_reg(REG_CELL_WIDTH, 12'd0);
    write_reg(REG_CELLS_ACROSS, 12'd0);
    send_item(KIND_OFFER, 16'd0, 16'd0, 32'd1, 16'h0010, 10'd0);
    settle();
    write_reg(REG_CELLS_ACROSS, 12'hFFF);
    send_item(KIND_OFFER, 16'hFFFF, 16'd0, 32'd1, 16'h0011, 10'd0);
    send_item(KIND_OFFER, 16'd32736, 16'd0, 32'd1, 16'h0012, 10'd0);
    send_item(KIND_OFFER, 16'd16383, 16'd15, 32'd7, 16'h0013, 10'd0);
    send_item(KIND_DRAIN, 16'h0, 16'h0, 32'h0, 16'h0, 10'd1023);
    settle();
    write_reg(REG_CELL_HEIGHT, 12'hFFF);
    write_reg(REG_CELL_WIDTH, 12'hFFF);
    write_reg(REG_CELLS_ACROSS, 12'd1);
    write_reg(REG_UNUSED, 12'hFFF);
    send_item(KIND_OFFER, 16'hFFFF, 16'hFFFF, 32'd9, 16'h0014, 10'd0);
    send_item(KIND_DRAIN, 16'h0, 16'h0, 32'h0, 16'h0, 10'd1);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    int unsigned ch16;
    int unsigned cw16;
    int unsigned rows;
    int unsigned cols;
    int unsigned xlim;
    int unsigned ylim;
    logic        kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] ps;
    logic [9:0]  dcell;
    for (phase = 0; phase < 7; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_CELL_HEIGHT, 12'd32);
          write_reg(REG_CELL_WIDTH, 12'd32);
          write_reg(REG_CELLS_ACROSS, 12'd21);
        end
        1: begin
          write_reg(REG_CELL_HEIGHT, 12'd1);
          write_reg(REG_CELL_WIDTH, 12'd1);
          write_reg(REG_CELLS_ACROSS, 12'd1024);
        end
        2: begin
          write_reg(REG_CELL_HEIGHT, 12'd4);
          write_reg(REG_CELL_WIDTH, 12'd4);
          write_reg(REG_CELLS_ACROSS, 12'd32);
        end
        4: begin
          write_reg(REG_CELL_HEIGHT, 12'd4095);
          write_reg(REG_CELL_WIDTH, 12'd4095);
          write_reg(REG_CELLS_ACROSS, 12'd1);
        end
        5: begin
          write_reg(REG_CELL_HEIGHT, 12'($urandom_range(1, 4095)));
          write_reg(REG_CELL_WIDTH, 12'($urandom_range(1, 4095)));
          write_reg(REG_CELLS_ACROSS, 12'($urandom_range(1, 1024)));
        end
        default: begin
          write_reg(REG_CELL_HEIGHT, 12'($urandom_range(1, 48)));
          write_reg(REG_CELL_WIDTH, 12'($urandom_range(1, 48)));
          write_reg(REG_CELLS_ACROSS, 12'($urandom_range(1, 40)));
        end
      endcase
      // one phase runs back to back on both sides
      in_gaps_on    = (phase != 2);
      out_stalls_on = (phase != 2);
      ch16 = ((cur_cell_h == 0) ? 1 : cur_cell_h) * 16;
      cw16 = ((cur_cell_w == 0) ? 1 : cur_cell_w) * 16;
      cols = cur_cells_across;
      rows = NUM_CELLS / cols;
      if (rows == 0) begin
        rows = 1;
        cols = NUM_CELLS;
      end
      xlim = cols * cw16 - 1;
      ylim = rows * ch16 - 1;
      if (xlim > 65535) xlim = 65535;
      if (ylim > 65535) ylim = 65535;
      for (n = 0; n < 200; n++) begin
        pick  = $urandom_range(0, 99);
        kind  = KIND_OFFER;
        px    = 16'($urandom);
        py    = 16'($urandom);
        ps    = $urandom;
        dcell = 10'($urandom);
        if (pick < 15) begin
          kind = 1'($urandom);
        end else if (pick < 40) begin
          kind = KIND_DRAIN;
          if (filled_cells.size() != 0 && $urandom_range(0, 3) != 0)
            dcell = 10'(filled_cells[$urandom_range(0, filled_cells.size() - 1)]);
        end else begin
          // a point inside the grid, strengths often close so cells contend
          px   = 16'($urandom_range(0, xlim));
          py   = 16'($urandom_range(0, ylim));
          pick = $urandom_range(0, 99);
          if (pick < 25)
            ps = $urandom_range(0, 7);
          else if (pick < 35)
            ps = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        send_item(kind, px, py, ps, 16'($urandom), dcell);
      end
    end
  endtask

  initial begin : main
    int unsigned i;
    cur_cell_h       = 12'd32;
    cur_cell_w       = 12'd32;
    cur_cells_across = 11'd21;
    for (i = 0; i < NUM_CELLS; i++) begin
      best_strength[i] = '0;
      best_x[i]        = '0;
      best_y[i]        = '0;
      best_tag[i]      = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("[grid_cell_best_keypoint_select] OK");
    end else begin
      $display("[grid_cell_best_keypoint_select] ERROR");
    end
    $finish;
  end

endmodule
